// ----- hw/rtl/hcbp_pkg.sv -----
`default_nettype none

package hcbp_pkg;

  // Operation codes carried by an input request.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef enum logic [1:0] {
    KIND_FULL    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_COUNT   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic        last;
  } res_t;

  // Result queue sizing.
  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

endpackage

`default_nettype wire

// ----- hw/rtl/hcbp_in_if.sv -----
`default_nettype none

interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  symbol;
  logic [31:0] code_bits;
  logic [5:0]  code_length;

  modport source (output valid, output op, output symbol, output code_bits,
                  output code_length, input ready);
  modport sink (input valid, input op, input symbol, input code_bits,
                input code_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hcbp_out_if.sv -----
`default_nettype none

interface hcbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [1:0]  kind;
  logic        last;

  modport source (output valid, output word, output kind, output last, input ready);
  modport sink (input valid, input word, input kind, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/huffman_code_bit_packer_unit.sv -----
`default_nettype none
// A request is registered into the packing stage together with its code table read, and
// its results are written into the result queue, from which out_ch offers them.
// Throughput: one request per cycle; the code table read is registered in the RAM and
// the packing stage handles one request per cycle. A finish request yields up to two
// results, and the input stalls only when the eight-entry result queue runs short of room.
// Reset (synchronous, active low) clears the stream state and the per-entry valid flags of
// the code table at once, so every symbol reads as absent; no clearing sweep is needed.

module huffman_code_bit_packer_unit #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int WORD_BITS    = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
  localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
  localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
  localparam int P_W       = $clog2(WORD_BITS);
  localparam int CW        = $clog2(2 * WORD_BITS) + 1;
  localparam int ENT_W     = LEN_LIMIT + LEN_W;

  // Input side.
  logic              in_acc;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;
  logic [5:0]        len_sat;
  logic [LEN_LIMIT-1:0] code_mask;
  logic              tbl_we;
  logic [ENT_W-1:0]  tbl_wdata;
  logic [ENT_W-1:0]  tbl_rdata;

  logic [SYMBOL_COUNT-1:0] valid_r, valid_nxt;

  // Packing stage registers.
  logic       s1_v_r;
  logic [1:0] s1_op_r;
  logic [7:0] s1_sym_r;
  logic       s1_inr_r;
  logic       s1_vld_r;

  // Stream state.
  logic [WORD_BITS-1:0] pend_r, pend_nxt;
  logic [P_W-1:0]       pos_r, pos_nxt;
  logic [31:0]          total_r, total_nxt;
  logic                 has_r, has_nxt;

  logic [LEN_W-1:0]       ent_len;
  logic [WORD_BITS-1:0]   code_w;
  logic [CW-1:0]          l_ext, p_ext, sh;
  logic                   fill;
  logic [2*WORD_BITS-1:0] merged;

  logic [1:0]     push_cnt;
  hcbp_pkg::res_t push0, push1, head;
  logic [hcbp_pkg::RES_CNT_W-1:0] fifo_cnt;
  logic [hcbp_pkg::RES_CNT_W:0]   fifo_need;

  // The result queue must hold whatever the request in the packing stage and the
  // next accepted one can produce, two results each at most.
  assign fifo_need   = (hcbp_pkg::RES_CNT_W + 1)'(fifo_cnt) +
                       (s1_v_r ? (hcbp_pkg::RES_CNT_W + 1)'(2) : '0);
  assign in_ch.ready = fifo_need <= (hcbp_pkg::RES_CNT_W + 1)'(hcbp_pkg::RES_FIFO_DEPTH - 2);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign in_range = {1'b0, in_ch.symbol} < 9'(SYMBOL_COUNT);
  assign in_addr  = in_ch.symbol[ADDR_W-1:0];

  always_comb begin
    len_sat   = (in_ch.code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : in_ch.code_length;
    code_mask = ~({LEN_LIMIT{1'b1}} << len_sat);
    tbl_wdata = {LEN_W'(len_sat), in_ch.code_bits[LEN_LIMIT-1:0] & code_mask};
    tbl_we    = in_acc && (in_ch.op == hcbp_pkg::OP_LOAD) && in_range;
    valid_nxt = valid_r;
    if (tbl_we) begin
      valid_nxt[in_addr] = 1'b1;
    end
  end

  hcbp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_code_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(in_addr),
    .wdata(tbl_wdata),
    .raddr(in_addr),
    .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      s1_v_r  <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= in_ch.op;
    s1_sym_r <= in_ch.symbol;
    s1_inr_r <= in_range;
    s1_vld_r <= in_range && valid_r[in_addr];
  end

  // Packing: the codeword is shifted into a double-width window below the pending
  // word, so a codeword that crosses a word boundary spills into the lower half.
  always_comb begin
    ent_len = s1_vld_r ? tbl_rdata[ENT_W-1 -: LEN_W] : '0;
    code_w  = WORD_BITS'(tbl_rdata[LEN_LIMIT-1:0]);
    l_ext   = CW'(ent_len);
    p_ext   = CW'(pos_r);
    fill    = l_ext > p_ext;
    sh      = CW'(WORD_BITS) + p_ext + CW'(1) - l_ext;
    merged  = {pend_r, {WORD_BITS{1'b0}}} | ({{WORD_BITS{1'b0}}, code_w} << sh);

    pend_nxt  = pend_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    has_nxt   = has_r;
    push_cnt  = 2'd0;
    push0     = '{word: '0, kind: hcbp_pkg::KIND_FULL, last: 1'b1};
    push1     = '{word: '0, kind: hcbp_pkg::KIND_COUNT, last: 1'b1};

    if (s1_v_r) begin
      case (s1_op_r)
        hcbp_pkg::OP_ENCODE: begin
          if (!s1_inr_r || (ent_len == '0)) begin
            push_cnt  = 2'd1;
            push0     = '{word: 32'(s1_sym_r), kind: hcbp_pkg::KIND_ERROR, last: 1'b1};
            pend_nxt  = '0;
            pos_nxt   = P_W'(WORD_BITS - 1);
            total_nxt = '0;
            has_nxt   = 1'b0;
          end else begin
            total_nxt = total_r + 32'(ent_len);
            if (fill) begin
              push_cnt = 2'd1;
              push0    = '{word: 32'(merged[2*WORD_BITS-1:WORD_BITS]),
                           kind: hcbp_pkg::KIND_FULL, last: 1'b1};
              pend_nxt = merged[WORD_BITS-1:0];
              pos_nxt  = P_W'(p_ext + CW'(WORD_BITS) - l_ext);
              has_nxt  = l_ext != (p_ext + CW'(1));
            end else begin
              pend_nxt = merged[2*WORD_BITS-1:WORD_BITS];
              pos_nxt  = P_W'(p_ext - l_ext);
              has_nxt  = 1'b1;
            end
          end
        end
        hcbp_pkg::OP_FINISH: begin
          if (has_r) begin
            push_cnt = 2'd2;
            push0    = '{word: 32'(pend_r), kind: hcbp_pkg::KIND_PARTIAL, last: 1'b0};
            push1    = '{word: total_r, kind: hcbp_pkg::KIND_COUNT, last: 1'b1};
          end else begin
            push_cnt = 2'd1;
            push0    = '{word: total_r, kind: hcbp_pkg::KIND_COUNT, last: 1'b1};
          end
          pend_nxt  = '0;
          pos_nxt   = P_W'(WORD_BITS - 1);
          total_nxt = '0;
          has_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      pos_r   <= P_W'(WORD_BITS - 1);
      total_r <= '0;
      has_r   <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      has_r   <= has_nxt;
    end
  end

  hcbp_result_fifo u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_cnt(push_cnt),
    .push0   (push0),
    .push1   (push1),
    .pop     (out_ch.valid && out_ch.ready),
    .head    (head),
    .count   (fifo_cnt)
  );

  assign out_ch.valid = fifo_cnt != '0;
  assign out_ch.word  = head.word;
  assign out_ch.kind  = head.kind;
  assign out_ch.last  = head.last;

endmodule

`default_nettype wire

// ----- hw/rtl/hcbp_ram.sv -----
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hcbp_result_fifo.sv -----
`default_nettype none

module hcbp_result_fifo (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [1:0]                         push_cnt,
  input  wire hcbp_pkg::res_t                     push0,
  input  wire hcbp_pkg::res_t                     push1,
  input  wire logic                               pop,
  output hcbp_pkg::res_t                          head,
  output logic [hcbp_pkg::RES_CNT_W-1:0]          count
);

  hcbp_pkg::res_t mem [hcbp_pkg::RES_FIFO_DEPTH];

  logic [hcbp_pkg::RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hcbp_pkg::RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hcbp_pkg::RES_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + hcbp_pkg::RES_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + hcbp_pkg::RES_PTR_W'(pop);
    count_nxt  = count_r + hcbp_pkg::RES_CNT_W'(push_cnt) - hcbp_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + hcbp_pkg::RES_PTR_W'(1)] <= push1;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1200;

  logic clk;
  logic rst_n;

  hcbp_in_if  req_ch ();
  hcbp_out_if res_ch ();

  huffman_code_bit_packer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Predicted state of the packer.
  logic [31:0] code_tbl [256];
  logic [5:0]  len_tbl  [256];
  logic [31:0] open_word;
  int          fill_pos;
  logic [31:0] stream_bits;
  logic        open_has_bits;

  hcbp_pkg::res_t words_due [$];
  int   error_count;
  int   burst_left;
  bit   hold_off_req;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void restart_stream();
    open_word     = '0;
    fill_pos      = 31;
    stream_bits   = '0;
    open_has_bits = 1'b0;
  endfunction

  function automatic void expect_result(logic [31:0] word, hcbp_pkg::kind_t kind, logic last);
    hcbp_pkg::res_t r;
    r.word = word;
    r.kind = kind;
    r.last = last;
    words_due.push_back(r);
  endfunction

  function automatic void pack_request(logic [1:0] op, logic [7:0] sym, logic [31:0] bits,
                                       logic [5:0] len);
    logic [5:0] eff_len;
    bit         word_out;
    int         i;
    case (op)
      hcbp_pkg::OP_LOAD: begin
        eff_len = (len > 6'd32) ? 6'd32 : len;
        len_tbl[sym]  = eff_len;
        code_tbl[sym] = (eff_len == 6'd32) ? bits : bits & ((32'd1 << eff_len) - 32'd1);
      end
      hcbp_pkg::OP_ENCODE: begin
        if (len_tbl[sym] == 6'd0) begin
          expect_result({24'd0, sym}, hcbp_pkg::KIND_ERROR, 1'b1);
          restart_stream();
        end else begin
          word_out = 1'b0;
          for (i = int'(len_tbl[sym]) - 1; i >= 0; i--) begin
            if (code_tbl[sym][i]) open_word[fill_pos] = 1'b1;
            stream_bits = stream_bits + 32'd1;
            if (fill_pos == 0) begin
              // A codeword is never longer than a word, so at most one word fills.
              if (!word_out) expect_result(open_word, hcbp_pkg::KIND_FULL, 1'b1);
              word_out      = 1'b1;
              open_word     = '0;
              fill_pos      = 31;
              open_has_bits = 1'b0;
            end else begin
              fill_pos--;
              open_has_bits = 1'b1;
            end
          end
        end
      end
      hcbp_pkg::OP_FINISH: begin
        if (open_has_bits) expect_result(open_word, hcbp_pkg::KIND_PARTIAL, 1'b0);
        expect_result(stream_bits, hcbp_pkg::KIND_COUNT, 1'b1);
        restart_stream();
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one request in bursts with random gaps and returns once it is accepted.
  task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                              input logic [31:0] bits, input logic [5:0] len);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.symbol      <= sym;
    req_ch.code_bits   <= bits;
    req_ch.code_length <= len;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pack_request(op, sym, bits, len);
    burst_left--;
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  task automatic test_empty_table();
    send_request(hcbp_pkg::OP_ENCODE, 8'd0, 32'd0, 6'd0);
    send_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(hcbp_pkg::OP_FINISH, 8'd0, 32'd0, 6'd0);
  endtask

  task automatic test_table_loads();
    send_request(hcbp_pkg::OP_LOAD, 8'd0,   32'hFFFF_FFFF, 6'd1);
    send_request(hcbp_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_request(hcbp_pkg::OP_LOAD, 8'd1,   32'hA5A5_A5A5, 6'h3F);
    send_request(hcbp_pkg::OP_LOAD, 8'd2,   32'h0000_0000, 6'd33);
    send_request(hcbp_pkg::OP_LOAD, 8'd3,   32'hFFFF_FFF5, 6'd3);
    send_request(hcbp_pkg::OP_LOAD, 8'd4,   32'h1234_5678, 6'd0);
  endtask

  task automatic test_word_packing();
    send_request(hcbp_pkg::OP_ENCODE, 8'd0,   32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd3,   32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd255, 32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd1,   32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd3,   32'd0, 6'd0);
    send_request(hcbp_pkg::OP_FINISH, 8'd0,   32'd0, 6'd0);
  endtask

  task automatic test_stream_discard();
    send_request(hcbp_pkg::OP_ENCODE, 8'd3, 32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd4, 32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd2, 32'd0, 6'd0);
    send_request(hcbp_pkg::OP_FINISH, 8'd0, 32'd0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'd0, 32'd0, 6'd0);
    send_request(hcbp_pkg::OP_FINISH, 8'd0, 32'd0, 6'd0);
  endtask

  // Every encode fills a word while the receiver holds off, so the result queue
  // fills and the input must stall.
  task automatic test_backpressure();
    int k;
    send_request(hcbp_pkg::OP_LOAD, 8'h80, $urandom, 6'd32);
    wait_for_results();
    hold_off_req = 1'b1;
    for (k = 0; k < 40; k++) begin
      send_request(hcbp_pkg::OP_ENCODE, 8'h80, $urandom, 6'($urandom));
    end
    send_request(hcbp_pkg::OP_FINISH, 8'd0, 32'd0, 6'd0);
    wait_for_results();
  endtask

  task automatic test_random_streams();
    logic [7:0] alphabet [$];
    logic [7:0] sym;
    logic [5:0] len;
    int         sent;
    int         stream_no;
    int         k;
    int         n_alpha;
    int         n_enc;
    int         pick;
    sent = 0;
    stream_no = 0;
    while (sent < RANDOM_ITEMS) begin
      alphabet.delete();
      n_alpha = $urandom_range(1, 12);
      for (k = 0; k < n_alpha; k++) begin
        sym = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
          0:       len = 6'd0;
          1:       len = 6'($urandom_range(33, 63));
          2, 3, 4: len = 6'($urandom_range(13, 32));
          default: len = 6'($urandom_range(1, 12));
        endcase
        send_request(hcbp_pkg::OP_LOAD, sym, $urandom, len);
        if (len != 6'd0) alphabet.push_back(sym);
        sent++;
      end
      n_enc = $urandom_range(1, 60);
      for (k = 0; k < n_enc; k++) begin
        pick = $urandom_range(0, 49);
        if (pick == 0) begin
          send_request(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom));
        end else begin
          // Now and then a symbol from the whole range, which may be absent.
          if (pick == 1 || alphabet.size() == 0) sym = 8'($urandom_range(0, 255));
          else sym = alphabet[$urandom_range(0, alphabet.size() - 1)];
          send_request(hcbp_pkg::OP_ENCODE, sym, $urandom, 6'($urandom));
          sent++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        send_request(hcbp_pkg::OP_FINISH, 8'($urandom), $urandom, 6'($urandom));
        sent++;
      end
      stream_no++;
      if (stream_no % 8 == 0) wait_for_results();
    end
  endtask

  initial begin
    error_count  = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    for (int s = 0; s < 256; s++) begin
      code_tbl[s] = '0;
      len_tbl[s]  = '0;
    end
    restart_stream();
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= hcbp_pkg::OP_LOAD;
    req_ch.symbol      <= '0;
    req_ch.code_bits   <= '0;
    req_ch.code_length <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_table_loads();
    test_word_packing();
    test_stream_discard();
    test_backpressure();
    test_random_streams();

    wait_for_results();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("huffman_code_bit_packer_unit regression: pass");
    end else begin
      $display("huffman_code_bit_packer_unit regression: fail");
    end
    $finish;
  end

  // Receiver: picks a new stall pattern for each phase of random length, and on request
  // holds off completely for a long stretch.
  initial begin : receiver
    int mode;
    int phase_left;
    int hold_left;
    int tick;
    mode = 0;
    phase_left = 0;
    hold_left = 0;
    tick = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        tick++;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= 1'($urandom_range(0, 1));
          2:       res_ch.ready <= (tick % 4 == 0);
          default: res_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    hcbp_pkg::res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected result: word %h kind %0d last %0d",
               res_ch.word, res_ch.kind, res_ch.last);
        error_count++;
      end else begin
        want = words_due.pop_front();
        if (res_ch.word !== want.word) begin
          $error("word: expected %h, got %h", want.word, res_ch.word);
          error_count++;
        end
        if (res_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
          error_count++;
        end
        if (res_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_ch.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("huffman_code_bit_packer_unit regression: fail");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_in_if.sv
hw/rtl/hcbp_out_if.sv
hw/rtl/hcbp_ram.sv
hw/rtl/hcbp_result_fifo.sv
hw/rtl/huffman_code_bit_packer_unit.sv
bench/testbench.sv
